### hdl/ipid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared widths, microcode types, control structs and the control ROM of the
// incremental PID core.
// ----------------------------------------------------------------------------
package ipid_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 48;
  localparam int COEF_W     = 32;
  localparam int DRIVE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int SUM_LO_W = SUM_W / 2;
  localparam int SUM_HI_W = SUM_W - SUM_LO_W;

  // Multiplier B operand: error, zero-extended low half or signed high half of the sum
  localparam int MUL_B_W0 = (ERR_W > SUM_HI_W) ? ERR_W : SUM_HI_W;
  localparam int MUL_B_W  = (MUL_B_W0 > SUM_LO_W + 1) ? MUL_B_W0 : SUM_LO_W + 1;
  localparam int MUL_P_W  = COEF_W + MUL_B_W;

  // Three-term error sum and the increment taken from it
  localparam int ACC1_W    = COEF_W + ERR_W + 2;
  localparam int DELTA_W   = ACC1_W - FRAC_W;
  localparam int SUM_EXT_W = ((SUM_W > DELTA_W) ? SUM_W : DELTA_W) + 1;

  // Accumulator holds the full gain product, which is the wider phase
  localparam int ACC_W = COEF_W + SUM_W;
  localparam int QUO_W = ACC_W - FRAC_W;

  // Control program
  localparam int PROG_LEN = 10;
  localparam int STEP_W   = $clog2(PROG_LEN);
  localparam logic [STEP_W-1:0] STEP_FIRST = '0;
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(PROG_LEN - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A   = 3'd0,
    CFG_COEF_B   = 3'd1,
    CFG_COEF_C   = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_TARGET   = 3'd4,
    CFG_LOWER    = 3'd5,
    CFG_UPPER    = 3'd6,
    CFG_CLAMP_EN = 3'd7
  } cfg_idx_e;

  localparam logic signed [COEF_W-1:0] GAIN_RESET = COEF_W'(65536);

  // Operand selects
  typedef enum logic [1:0] {
    A_COEF_A,
    A_COEF_B,
    A_COEF_C,
    A_GAIN
  } a_sel_e;

  typedef enum logic [2:0] {
    B_ERR0,
    B_ERR1,
    B_ERR2,
    B_SUM_LO,
    B_SUM_HI
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_e;

  // One control word of the program
  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    sum_upd;
    logic    out_wr;
    jmp_e    jmp;
  } ucode_t;

  // Control handed from sequencer to datapath, handshake-qualified
  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    sum_upd;
    logic    load_err;
    logic    out_wr;
  } ctrl_t;

  // Configuration register bank
  typedef struct packed {
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [COEF_W-1:0]   coef_b;
    logic signed [COEF_W-1:0]   coef_c;
    logic signed [COEF_W-1:0]   gain;
    logic signed [SAMPLE_W-1:0] target;
    logic signed [DRIVE_W-1:0]  lower;
    logic signed [DRIVE_W-1:0]  upper;
    logic                       clamp_en;
  } cfg_t;

  localparam ucode_t UC_NOP = '{
    a_sel:   A_COEF_A,
    b_sel:   B_ERR0,
    acc_op:  ACC_HOLD,
    sum_upd: 1'b0,
    out_wr:  1'b0,
    jmp:     JMP_NEXT
  };

  // Control ROM: error terms, sum update, gain product, result write
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    w = UC_NOP;
    unique case (step)
      4'd0: begin
        w.jmp = JMP_WAIT_IN;                 // wait for a sample
      end
      4'd1: begin
        w.a_sel = A_COEF_A; w.b_sel = B_ERR0;
      end
      4'd2: begin
        w.a_sel = A_COEF_B; w.b_sel = B_ERR1; w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.a_sel = A_COEF_C; w.b_sel = B_ERR2; w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.sum_upd = 1'b1;                    // saturating sum, error history shift
      end
      4'd6: begin
        w.a_sel = A_GAIN; w.b_sel = B_SUM_LO;
      end
      4'd7: begin
        w.a_sel = A_GAIN; w.b_sel = B_SUM_HI; w.acc_op = ACC_LOAD;
      end
      4'd8: begin
        w.acc_op = ACC_ADD_HI;
      end
      4'd9: begin
        w.out_wr = 1'b1; w.jmp = JMP_WAIT_OUT;
      end
      default: begin
        w = UC_NOP;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### hdl/ipid_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_if
// Valid/ready channels of the incremental PID core: sample in, result out.
// ----------------------------------------------------------------------------
interface ipid_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ipid_pkg::SAMPLE_W-1:0] measured_sample;

  modport source (output valid, output measured_sample, input ready);
  modport sink   (input valid, input measured_sample, output ready);
endinterface

interface ipid_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipid_pkg::DRIVE_W-1:0] drive_value;
  logic                                was_clamped;

  modport source (output valid, output drive_value, output was_clamped, input ready);
  modport sink   (input valid, input drive_value, input was_clamped, output ready);
endinterface
`default_nettype wire

### hdl/ipid_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_sequencer
// Step counter over the control ROM; waits on the sample transfer and on a
// free result register.
// ----------------------------------------------------------------------------
module ipid_sequencer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           out_busy_i,
  output logic                in_ready_o,
  output ipid_pkg::ctrl_t     ctrl_o
);
  import ipid_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              in_xfer;

  assign uc         = ucode_rom(step_q);
  assign in_ready_o = (uc.jmp == JMP_WAIT_IN);
  assign in_xfer    = in_ready_o && in_valid_i;

  // Next step
  always_comb begin
    step_d = step_q;
    unique case (uc.jmp)
      JMP_NEXT:     step_d = step_q + 1'b1;
      JMP_WAIT_IN:  if (in_valid_i) step_d = step_q + 1'b1;
      JMP_WAIT_OUT: if (!out_busy_i) step_d = STEP_FIRST;
      default:      step_d = STEP_FIRST;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FIRST;
    end else begin
      step_q <= step_d;
    end
  end

  // Control word, gated by the handshakes
  always_comb begin
    ctrl_o.a_sel    = uc.a_sel;
    ctrl_o.b_sel    = uc.b_sel;
    ctrl_o.acc_op   = uc.acc_op;
    ctrl_o.sum_upd  = uc.sum_upd;
    ctrl_o.load_err = in_xfer;
    ctrl_o.out_wr   = uc.out_wr && !out_busy_i;
  end

  // Checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (step_q == STEP_W'(1)))
    else $error("sample transfer did not start the program");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_LAST && !out_busy_i) |=> (step_q == STEP_FIRST && in_ready_o))
    else $error("program did not return to the wait step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_LAST && out_busy_i) |=> (step_q == STEP_LAST))
    else $error("result step left while result register busy");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != STEP_FIRST && step_q != STEP_LAST) |=>
      (step_q == STEP_W'($past(step_q) + 1'b1)))
    else $error("program step skipped");

endmodule
`default_nettype wire

### hdl/ipid_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_datapath
// Shared signed multiplier, product and accumulator registers, error history,
// saturating running sum, and drive saturation and clamping.
// ----------------------------------------------------------------------------
module ipid_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire ipid_pkg::ctrl_t                      ctrl_i,
  input  wire ipid_pkg::cfg_t                       cfg_i,
  input  wire logic signed [ipid_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [ipid_pkg::DRIVE_W-1:0]       drive_o,
  output logic                                      clamped_o
);
  import ipid_pkg::*;

  logic signed [ERR_W-1:0]   err0_q, err1_q, err2_q, err_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]   prod_ext, acc_d, acc_q;

  // New error from the transferred sample
  assign err_d = {cfg_i.target[SAMPLE_W-1], cfg_i.target}
               - {sample_i[SAMPLE_W-1], sample_i};

  // Operand select
  always_comb begin
    unique case (ctrl_i.a_sel)
      A_COEF_A: mul_a = cfg_i.coef_a;
      A_COEF_B: mul_a = cfg_i.coef_b;
      A_COEF_C: mul_a = cfg_i.coef_c;
      A_GAIN:   mul_a = cfg_i.gain;
      default:  mul_a = cfg_i.coef_a;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.b_sel)
      B_ERR0:   mul_b = {{(MUL_B_W-ERR_W){err0_q[ERR_W-1]}}, err0_q};
      B_ERR1:   mul_b = {{(MUL_B_W-ERR_W){err1_q[ERR_W-1]}}, err1_q};
      B_ERR2:   mul_b = {{(MUL_B_W-ERR_W){err2_q[ERR_W-1]}}, err2_q};
      B_SUM_LO: mul_b = {{(MUL_B_W-SUM_LO_W){1'b0}}, sum_q[SUM_LO_W-1:0]};
      B_SUM_HI: mul_b = {{(MUL_B_W-SUM_HI_W){sum_q[SUM_W-1]}}, sum_q[SUM_W-1:SUM_LO_W]};
      default:  mul_b = '0;
    endcase
  end

  // Shared multiplier, registered
  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-MUL_P_W){prod_q[MUL_P_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulator
  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_LOAD:   acc_d = prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      ACC_ADD_HI: acc_d = acc_q + (prod_ext <<< SUM_LO_W);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Running sum: add floor(acc / 2^16), saturate to the sum range
  logic signed [DELTA_W-1:0]   delta;
  logic signed [SUM_EXT_W-1:0] sum_ext;
  logic                        sum_in_range;

  always_comb begin
    delta   = acc_q[DELTA_W+FRAC_W-1:FRAC_W];
    sum_ext = {{(SUM_EXT_W-SUM_W){sum_q[SUM_W-1]}}, sum_q}
            + {{(SUM_EXT_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    sum_in_range = (&sum_ext[SUM_EXT_W-1:SUM_W-1]) || !(|sum_ext[SUM_EXT_W-1:SUM_W-1]);
    if (sum_in_range) begin
      sum_d = sum_ext[SUM_W-1:0];
    end else if (sum_ext[SUM_EXT_W-1]) begin
      sum_d = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_d = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // Loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err0_q <= '0;
      err1_q <= '0;
      err2_q <= '0;
      sum_q  <= '0;
    end else begin
      if (ctrl_i.load_err) begin
        err0_q <= err_d;
      end
      if (ctrl_i.sum_upd) begin
        sum_q  <= sum_d;
        err1_q <= err0_q;
        err2_q <= err1_q;
      end
    end
  end

  // Drive: floor(sum * gain / 2^16) saturated, then optional clamp
  logic signed [QUO_W-1:0]   quo;
  logic                      drv_in_range;
  logic signed [DRIVE_W-1:0] scaled;

  always_comb begin
    quo          = acc_q[ACC_W-1:FRAC_W];
    drv_in_range = (&quo[QUO_W-1:DRIVE_W-1]) || !(|quo[QUO_W-1:DRIVE_W-1]);
    if (drv_in_range) begin
      scaled = quo[DRIVE_W-1:0];
    end else if (quo[QUO_W-1]) begin
      scaled = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
    drive_o   = scaled;
    clamped_o = !drv_in_range;
    if (cfg_i.clamp_en) begin
      if (scaled > cfg_i.upper) begin
        drive_o   = cfg_i.upper;
        clamped_o = 1'b1;
      end else if (scaled < cfg_i.lower) begin
        drive_o   = cfg_i.lower;
        clamped_o = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/incremental_pid_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_controller_core
// Velocity-form PID: saturating running sum of weighted errors, scaled by an
// output gain, with optional drive clamping.
// ----------------------------------------------------------------------------
// One 32x25 signed multiplier is shared by the three error terms and the two
// halves of the gain product, stepped by a 10-word control program. A sample
// is taken only in the program's first step; the result goes to an output
// register, so a finished result may wait for its transfer while the next
// sample is taken, and the program stalls in its last step only while an
// earlier result is still unclaimed. Configuration writes take effect on the
// next clock edge and are meant for idle periods.
// ----------------------------------------------------------------------------
module incremental_pid_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ipid_in_if.sink                                  sample_i,
  ipid_out_if.source                               result_o
);
  import ipid_pkg::*;

  cfg_t                      cfg_q;
  ctrl_t                     ctrl;
  logic                      out_busy;
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q, drive;
  logic                      clamped_q, clamped;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a   <= '0;
      cfg_q.coef_b   <= '0;
      cfg_q.coef_c   <= '0;
      cfg_q.gain     <= GAIN_RESET;
      cfg_q.target   <= '0;
      cfg_q.lower    <= '0;
      cfg_q.upper    <= '0;
      cfg_q.clamp_en <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_A:   cfg_q.coef_a   <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_B:   cfg_q.coef_b   <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_C:   cfg_q.coef_c   <= cfg_data_i[COEF_W-1:0];
        CFG_GAIN:     cfg_q.gain     <= cfg_data_i[COEF_W-1:0];
        CFG_TARGET:   cfg_q.target   <= cfg_data_i[SAMPLE_W-1:0];
        CFG_LOWER:    cfg_q.lower    <= cfg_data_i[DRIVE_W-1:0];
        CFG_UPPER:    cfg_q.upper    <= cfg_data_i[DRIVE_W-1:0];
        CFG_CLAMP_EN: cfg_q.clamp_en <= cfg_data_i[0];
        default:      cfg_q.clamp_en <= cfg_q.clamp_en;
      endcase
    end
  end

  assign out_busy = out_valid_q && !result_o.ready;

  ipid_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .out_busy_i (out_busy),
    .in_ready_o (sample_i.ready),
    .ctrl_o     (ctrl)
  );

  ipid_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .sample_i  (sample_i.measured_sample),
    .drive_o   (drive),
    .clamped_o (clamped)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_wr) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_wr) begin
      drive_q   <= drive;
      clamped_q <= clamped;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.drive_value = drive_q;
  assign result_o.was_clamped = clamped_q;

endmodule
`default_nettype wire
